// ----- sv/per_source_failure_rate_limiter_defines.svh -----
// Assertion macros for the per-source failure rate limiter.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PER_SOURCE_FAILURE_RATE_LIMITER_DEFINES_SVH
`define PER_SOURCE_FAILURE_RATE_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS

`define PSFRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PSFRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PSFRL_ASSERT(lbl, clk, rst_n, prop, msg)

`define PSFRL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/psfrl_pkg.sv -----
// Shared constants and types for the per-source failure rate limiter.
// No dependencies; used by every module of the block except psfrl_ram.
package psfrl_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

  localparam int OP_W = 2;
  localparam int ADDR_W = 32;
  localparam int TIME_W = 64;
  localparam int FCNT_W = 8;
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_FAILURE = 2'd1;
  localparam logic [OP_W-1:0] OP_SUCCESS = 2'd2;

  localparam logic CFG_WINDOW_LENGTH = 1'b0;
  localparam logic CFG_FAILURE_LIMIT = 1'b1;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 64'd60000000000;
  localparam logic [FCNT_W-1:0] LIMIT_RESET = 8'd5;
  localparam logic [FCNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [FCNT_W-1:0] COUNT_ONE = 8'd1;

  typedef struct packed {
    logic [FCNT_W-1:0] count;
    logic [TIME_W-1:0] start;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic expired;
    logic restart;
  } win_status_t;

endpackage

// ----- sv/per_source_failure_rate_limiter.sv -----
// Per-source failure rate limiter: scan sequencer, entry table and result register.
// Depends on psfrl_pkg, psfrl_ram, psfrl_window and the assertion macro header.
//
// Usage: each transfer on the in_ channel carries an opcode (check, record failure,
// record success), a source address and the current time. Every input transfer
// yields exactly one transfer on the out_ channel with is_allowed and table_full.
// The block scans its entry table through the single read port of the entry RAM,
// one entry per cycle, and stops early at a matching entry. A result comes sooner on
// an early hit than after a full scan; one item is in work at a time, so the next
// input transfer is accepted only once the previous item's result has been committed.
// in_tready is high only while no item is in work; a result still waiting on
// out_tready does not block the next accept, but the next result is held back
// (and its table update with it) until the previous one is taken.
// Reset empties the table at once through per-entry valid flops (no clearing
// pass), and sets window_length_ns to 60000000000 and failure_limit to 5.
// Configuration writes take effect on the next clock and belong to idle periods.
`include "per_source_failure_rate_limiter_defines.svh"

module per_source_failure_rate_limiter (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: opcode[1:0], source_address[33:2], time_now_ns[97:34], zero[103:98]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [psfrl_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: is_allowed[0], table_full[1], zero[7:2]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [psfrl_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [psfrl_pkg::TIME_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [psfrl_pkg::TIME_W-1:0]  window_len_r;
  logic [psfrl_pkg::FCNT_W-1:0]  limit_r;

  logic [psfrl_pkg::OP_W-1:0]    op_r;
  logic [psfrl_pkg::ADDR_W-1:0]  addr_r;
  logic [psfrl_pkg::TIME_W-1:0]  now_r;

  logic [psfrl_pkg::CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [psfrl_pkg::IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic                          free_ok_r, free_ok_nxt;
  logic [psfrl_pkg::IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [psfrl_pkg::IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [psfrl_pkg::TIME_W-1:0]  hit_start_r, hit_start_nxt;
  logic [psfrl_pkg::FCNT_W-1:0]  hit_count_r, hit_count_nxt;

  logic [psfrl_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [psfrl_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                          issue;
  logic [psfrl_pkg::IDX_W-1:0]   issue_idx;
  logic                          match;
  logic                          commit;
  logic                          allowed;
  logic                          full;
  logic [psfrl_pkg::FCNT_W-1:0]  next_count;

  logic                          ram_we;
  logic [psfrl_pkg::IDX_W-1:0]   ram_waddr;
  psfrl_pkg::entry_t             ram_wdata;
  psfrl_pkg::entry_t             ram_rdata;
  logic [$bits(psfrl_pkg::entry_t)-1:0] ram_rd_bits;

  psfrl_pkg::win_status_t        win;

  psfrl_ram #(
    .WIDTH ($bits(psfrl_pkg::entry_t)),
    .DEPTH (psfrl_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (issue_idx),
    .rd_data (ram_rd_bits)
  );

  assign ram_rdata = psfrl_pkg::entry_t'(ram_rd_bits);

  psfrl_window u_window (
    .time_now      (now_r),
    .window_start  (hit_start_r),
    .window_length (window_len_r),
    .status        (win)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign issue     = (scan_idx_r != psfrl_pkg::SCAN_END);
  assign issue_idx = scan_idx_r[psfrl_pkg::IDX_W-1:0];
  assign match     = chk_vld_r && valid_r[chk_idx_r] && (ram_rdata.addr == addr_r);
  assign commit    = (state_r == S_EXEC) && (!out_tvalid_r || out_tready);

  always_comb begin
    if (win.restart) begin
      next_count = psfrl_pkg::COUNT_ONE;
    end else if (hit_count_r == psfrl_pkg::COUNT_MAX) begin
      next_count = psfrl_pkg::COUNT_MAX;
    end else begin
      next_count = hit_count_r + psfrl_pkg::COUNT_ONE;
    end
  end

  // scan sequencer
  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = issue_idx;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_start_nxt = hit_start_r;
    hit_count_nxt = hit_count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = S_SCAN;
          scan_idx_nxt = '0;
          free_ok_nxt  = 1'b0;
          hit_nxt      = 1'b0;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = chk_idx_r;
          hit_start_nxt = ram_rdata.start;
          hit_count_nxt = ram_rdata.count;
          state_nxt     = S_EXEC;
        end else if (issue) begin
          chk_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
          if (!free_ok_r && !valid_r[issue_idx]) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = issue_idx;
          end
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // table update and result
  always_comb begin
    allowed   = 1'b0;
    full      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_r;
    ram_wdata = '{count: next_count, start: win.restart ? now_r : hit_start_r, addr: addr_r};
    valid_nxt = valid_r;
    unique case (op_r)
      psfrl_pkg::OP_CHECK: begin
        allowed = !hit_r || win.expired || (hit_count_r < limit_r);
      end
      psfrl_pkg::OP_FAILURE: begin
        if (hit_r) begin
          ram_we = commit;
        end else if (free_ok_r) begin
          ram_we    = commit;
          ram_waddr = free_idx_r;
          ram_wdata = '{count: psfrl_pkg::COUNT_ONE, start: now_r, addr: addr_r};
          if (commit) begin
            valid_nxt[free_idx_r] = 1'b1;
          end
        end else begin
          full = 1'b1;
        end
      end
      psfrl_pkg::OP_SUCCESS: begin
        if (hit_r && commit) begin
          valid_nxt[hit_idx_r] = 1'b0;
        end
      end
      default: begin
        allowed = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (commit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{(psfrl_pkg::OUT_DATA_W-2){1'b0}}, full, allowed};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      window_len_r <= psfrl_pkg::WINDOW_RESET;
      limit_r      <= psfrl_pkg::LIMIT_RESET;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      chk_vld_r    <= chk_vld_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          psfrl_pkg::CFG_WINDOW_LENGTH: window_len_r <= cfg_data;
          psfrl_pkg::CFG_FAILURE_LIMIT: limit_r <= cfg_data[psfrl_pkg::FCNT_W-1:0];
          default: limit_r <= limit_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r   <= in_tdata[psfrl_pkg::OP_W-1:0];
      addr_r <= in_tdata[psfrl_pkg::OP_W +: psfrl_pkg::ADDR_W];
      now_r  <= in_tdata[psfrl_pkg::OP_W + psfrl_pkg::ADDR_W +: psfrl_pkg::TIME_W];
    end
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    free_ok_r   <= free_ok_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_start_r <= hit_start_nxt;
    hit_count_r <= hit_count_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  `PSFRL_ASSERT(a_valid_only_on_exec, clk, rst_n, (state_r != S_EXEC) |=> $stable(valid_r), "entry valid bits changed outside the update step")
  `PSFRL_ASSERT(a_full_needs_full_table, clk, rst_n, (commit && full) |-> (&valid_r), "table_full reported with a free entry")
  `PSFRL_ASSERT(a_hit_is_valid, clk, rst_n, ((state_r == S_EXEC) && hit_r) |-> valid_r[hit_idx_r], "matched entry is not valid")
  `PSFRL_ASSERT(a_result_exclusive, clk, rst_n, out_tvalid_r |-> !(out_tdata_r[0] && out_tdata_r[1]), "is_allowed and table_full both set")

endmodule

// ----- sv/psfrl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psfrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rdata_r <= mem_r[rd_addr];
  end

  assign rd_data = rdata_r;

endmodule

// ----- sv/psfrl_window.sv -----
// Window expiry unit: one 64-bit subtract and compare per use, plus a zero check of the window start.
// Depends on psfrl_pkg.
module psfrl_window (
  input  logic [psfrl_pkg::TIME_W-1:0] time_now,
  input  logic [psfrl_pkg::TIME_W-1:0] window_start,
  input  logic [psfrl_pkg::TIME_W-1:0] window_length,
  output psfrl_pkg::win_status_t       status
);

  logic [psfrl_pkg::TIME_W-1:0] elapsed;

  assign elapsed = time_now - window_start;

  always_comb begin
    status.expired = (elapsed >= window_length);
    status.restart = status.expired || (window_start == '0);
  end

endmodule

// ----- dv/rate_limit_checker.sv -----
`timescale 1ns / 100ps
// Verdict checker for the per-source failure rate limiter: follows every transfer and
// register write, predicts is_allowed/table_full per request, compares. Uses psfrl_pkg.
module rate_limit_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [psfrl_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [psfrl_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [psfrl_pkg::TIME_W-1:0]     cfg_data,
  output int                               errors,
  output int                               pending
);
  import psfrl_pkg::*;

  typedef struct packed {
    logic table_full;
    logic is_allowed;
  } verdict_t;

  logic [TIME_W-1:0] window_ns;
  logic [FCNT_W-1:0] limit;
  logic              live [TABLE_ENTRIES];
  entry_t            slot [TABLE_ENTRIES];
  verdict_t          verdict_q [$];

  initial errors = 0;
  initial pending = 0;

  task automatic log_mismatch(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    errors++;
  endtask

  function automatic verdict_t apply_request(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] src,
                                             input logic [TIME_W-1:0] now_ns);
    verdict_t v;
    int hit;
    int spare;
    int i;
    logic lapsed;
    v = '0;
    hit = -1;
    spare = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && live[i] && slot[i].addr == src) hit = i;
      if (spare < 0 && !live[i]) spare = i;
    end
    lapsed = (hit >= 0) && ((now_ns - slot[hit].start) >= window_ns);
    case (op)
      OP_CHECK: begin
        v.is_allowed = (hit < 0) || lapsed || (slot[hit].count < limit);
      end
      OP_FAILURE: begin
        if (hit < 0 && spare < 0) begin
          v.table_full = 1'b1;
        end else if (hit < 0) begin
          live[spare] = 1'b1;
          slot[spare].addr = src;
          slot[spare].start = now_ns;
          slot[spare].count = COUNT_ONE;
        end else begin
          if (slot[hit].start == '0 || lapsed) begin
            slot[hit].start = now_ns;
            slot[hit].count = '0;
          end
          if (slot[hit].count < COUNT_MAX) slot[hit].count++;
        end
      end
      OP_SUCCESS: begin
        if (hit >= 0) live[hit] = 1'b0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      window_ns = WINDOW_RESET;
      limit = LIMIT_RESET;
      foreach (live[i]) live[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WINDOW_LENGTH) window_ns = cfg_data;
        else limit = cfg_data[FCNT_W-1:0];
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          log_mismatch($sformatf("result 0x%h with no request outstanding", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.is_allowed)
            log_mismatch($sformatf("is_allowed %b, predicted %b", out_tdata[0],
                                   want.is_allowed));
          if (out_tdata[1] !== want.table_full)
            log_mismatch($sformatf("table_full %b, predicted %b", out_tdata[1],
                                   want.table_full));
          if (out_tdata[OUT_DATA_W-1:2] !== '0)
            log_mismatch($sformatf("padding bits 0x%h not zero", out_tdata[OUT_DATA_W-1:2]));
        end
      end
      if (in_tvalid && in_tready)
        verdict_q.push_back(apply_request(in_tdata[OP_W-1:0],
                                          in_tdata[OP_W +: ADDR_W],
                                          in_tdata[OP_W + ADDR_W +: TIME_W]));
    end
    pending <= verdict_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the rate limiter testbench: clock, reset, request stimulus, result back-pressure,
// register phases, watchdog and verdict. Depends on psfrl_pkg, per_source_failure_rate_limiter and rate_limit_checker.
module testbench;
  import psfrl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TAIL = TABLE_ENTRIES + 8;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [TIME_W-1:0] WIN = WINDOW_RESET;
  localparam logic [ADDR_W-1:0] SRC_A = 32'h0A00_0001;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_index = CFG_WINDOW_LENGTH;
  logic [TIME_W-1:0]     cfg_data = '0;

  int errors;
  int pending;
  int stall_cycles = 0;
  int hold_requests = 0;
  bit quiet = 1'b0;
  bit finished = 1'b0;

  logic [TIME_W-1:0] now_ns = '0;
  logic [ADDR_W-1:0] base_addr = '0;
  int unsigned addr_span = 1;
  int unsigned step_max = 1;

  always #5 clk = ~clk;

  per_source_failure_rate_limiter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rate_limit_checker u_verdict_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] src,
                           input logic [TIME_W-1:0] stamp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= IN_DATA_W'({stamp, src, op});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_policy(input logic [TIME_W-1:0] window, input logic [FCNT_W-1:0] lim);
    drain(TAIL);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WINDOW_LENGTH;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= CFG_FAILURE_LIMIT;
    cfg_data <= TIME_W'(lim);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] advance_clock();
    if ($urandom_range(0, 19) == 0) now_ns = {$urandom, $urandom};
    else now_ns += TIME_W'($urandom_range(0, step_max));
    return now_ns;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_src();
    if ($urandom_range(0, 99) < 8) return $urandom;
    return base_addr + $urandom_range(0, addr_span - 1);
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int w_chk, input int w_fail,
                                              input int w_succ);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < w_chk) return OP_CHECK;
    if (roll < w_chk + w_fail) return OP_FAILURE;
    if (roll < w_chk + w_fail + w_succ) return OP_SUCCESS;
    return OP_UNUSED;
  endfunction

  task automatic random_burst(input int count, input int w_chk, input int w_fail,
                              input int w_succ);
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] src;
    logic [TIME_W-1:0] stamp;
    repeat (count) begin
      op = pick_op(w_chk, w_fail, w_succ);
      src = pick_src();
      stamp = advance_clock();
      send_item(op, src, stamp);
    end
  endtask

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    int wait_cycles;
    int holds_done;
    holds_done = 0;
    forever begin
      wait_cycles = quiet ? 0 : $urandom_range(0, 4);
      if (holds_done != hold_requests) begin
        wait_cycles = LONG_HOLD;
        holds_done++;
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !finished) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset policy (60 s window, limit 5).
    send_item(OP_CHECK, '0, '0);
    send_item(OP_FAILURE, SRC_A, '0);
    send_item(OP_FAILURE, SRC_A, 64'd10);
    for (i = 2; i <= 5; i++) send_item(OP_FAILURE, SRC_A, TIME_W'(10 * i));
    send_item(OP_CHECK, SRC_A, 64'd100);
    send_item(OP_CHECK, SRC_A, 64'd10 + WIN - 1);
    send_item(OP_CHECK, SRC_A, 64'd10 + WIN);
    send_item(OP_FAILURE, SRC_A, 64'd10 + WIN);
    send_item(OP_CHECK, SRC_A, 64'd11 + WIN);
    send_item(OP_SUCCESS, SRC_A, '0);
    send_item(OP_SUCCESS, SRC_A, '0);
    send_item(OP_CHECK, SRC_A, '0);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_FAILURE, '1, '1);
    send_item(OP_CHECK, '1, WIN - 2);
    send_item(OP_SUCCESS, '1, '1);

    // Zero window and zero limit: every window has lapsed.
    set_policy('0, '0);
    base_addr = $urandom;
    addr_span = 8;
    step_max = 50;
    random_burst(40, 40, 40, 15);

    // Short window, small limit; long result hold-off, then a full pause.
    set_policy(64'd1000, 8'd3);
    base_addr = $urandom;
    addr_span = 12;
    step_max = 300;
    random_burst(40, 35, 50, 10);
    hold_requests++;
    random_burst(40, 35, 50, 10);
    drain(2);
    random_burst(40, 35, 50, 10);

    // Widest window, top limit: hammer one source with failures towards count saturation.
    set_policy('1, COUNT_MAX);
    base_addr = $urandom;
    addr_span = 1;
    step_max = 1000;
    quiet = 1'b1;
    random_burst(140, 2, 97, 0);
    quiet = 1'b0;
    random_burst(140, 2, 97, 0);

    // Random policy: fill the table, then overflow it with new sources.
    set_policy({32'h0, $urandom}, FCNT_W'($urandom_range(1, 8)));
    base_addr = $urandom;
    step_max = 1 << 20;
    for (i = 0; i < TABLE_ENTRIES + 6; i++) send_item(OP_FAILURE, base_addr + i, advance_clock());
    addr_span = TABLE_ENTRIES + 16;
    random_burst(60, 30, 55, 10);

    drain(TAIL);
    finished = 1'b1;
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/psfrl_pkg.sv
sv/psfrl_ram.sv
sv/psfrl_window.sv
sv/per_source_failure_rate_limiter.sv
dv/rate_limit_checker.sv
dv/testbench.sv
